>>> rtl/eitu_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the external interrupt and timer unit
package eitu_pkg;

    localparam int unsigned TOD_W       = 64;
    localparam int unsigned CPUT_W      = 64;
    localparam int unsigned ITV_W       = 32;
    localparam int unsigned PARAM_W     = 32;
    localparam int unsigned SUB_W       = 5;
    localparam int unsigned PAGE_LO     = 12;
    localparam int unsigned PAGE_HI     = 30;
    localparam int unsigned PAGE_W      = PAGE_HI - PAGE_LO + 1;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned IN_DATA_W   = 168;
    localparam int unsigned OUT_DATA_W  = 40;

    localparam logic [ITV_W-1:0] INTERVAL_DECREMENT = ITV_W'(320);

    // subclass mask bit positions
    localparam int unsigned SUB_CPUT = 0;
    localparam int unsigned SUB_CMP  = 1;
    localparam int unsigned SUB_ITV  = 2;
    localparam int unsigned SUB_SERV = 3;
    localparam int unsigned SUB_KEY  = 4;

    typedef enum logic [2:0] {
        REQ_TICK     = 3'd0,
        REQ_CHECK    = 3'd1,
        REQ_SERVICE  = 3'd2,
        REQ_KEY      = 3'd3,
        REQ_LOAD_CPU = 3'd4,
        REQ_LOAD_ITV = 3'd5
    } req_t;

    typedef enum logic [2:0] {
        SRC_NONE    = 3'd0,
        SRC_CPUT    = 3'd1,
        SRC_CMP     = 3'd2,
        SRC_ITV     = 3'd3,
        SRC_SERVICE = 3'd4,
        SRC_KEY     = 3'd5
    } src_t;

    typedef enum logic {
        CFG_CLOCK_CMP   = 1'b0,
        CFG_PREFIX_BASE = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        req_t                      req_type;
        logic [TOD_W-1:0]          tod_value;
        logic signed [CPUT_W-1:0]  load_value;
        logic [PARAM_W-1:0]        service_param_in;
        logic                      ext_mask;
        logic [SUB_W-1:0]          subclass_mask;
        logic                      single_step;
    } item_t;

    typedef struct packed {
        logic                 interrupt_taken;
        src_t                 interrupt_source;
        logic [PARAM_W-1:0]   service_param_out;
        logic                 interrupt_possible;
    } result_t;

    // pipeline handshake between stages
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

>>> rtl/eitu_in_reg.sv
`timescale 1ns / 1ps
// input register: takes one item per cycle from the slave stream while it is empty or the result register advances
module eitu_in_reg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [eitu_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic [2:0]                          s_tuser,
    input  logic                                advance,
    output eitu_pkg::item_t                     item,
    output logic                                item_valid
);

    logic            valid_reg;
    logic            valid_next;
    eitu_pkg::item_t item_reg;
    logic            take;

    assign s_tready   = !valid_reg || advance;
    assign take       = s_tvalid && s_tready;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.req_type         <= eitu_pkg::req_t'(s_tuser);
            item_reg.tod_value        <= s_tdata[63:0];
            item_reg.load_value       <= $signed(s_tdata[127:64]);
            item_reg.service_param_in <= s_tdata[159:128];
            item_reg.ext_mask         <= s_tdata[160];
            item_reg.subclass_mask    <= s_tdata[165:161];
            item_reg.single_step      <= s_tdata[166];
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

>>> rtl/eitu_exec.sv
`timescale 1ns / 1ps
// timer state, configuration registers and the per-item update and interrupt pick
module eitu_exec (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [eitu_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  eitu_pkg::item_t                      item,
    input  logic                                 fire,
    output eitu_pkg::result_t                    result
);

    logic [eitu_pkg::TOD_W-1:0]   clock_cmp_reg;
    logic [eitu_pkg::PAGE_W-1:0]  prefix_page_reg;

    logic [eitu_pkg::TOD_W-1:0]   tod_reg;
    logic [eitu_pkg::TOD_W-1:0]   tod_next;
    logic [eitu_pkg::CPUT_W-1:0]  cpu_timer_reg;
    logic [eitu_pkg::CPUT_W-1:0]  cpu_timer_next;
    logic [eitu_pkg::ITV_W-1:0]   itv_reg;
    logic [eitu_pkg::ITV_W-1:0]   itv_next;
    logic                         itv_pend_reg;
    logic                         itv_pend_next;
    logic                         serv_pend_reg;
    logic                         serv_pend_next;
    logic [eitu_pkg::PARAM_W-1:0] serv_param_reg;
    logic [eitu_pkg::PARAM_W-1:0] serv_param_next;
    logic                         key_pend_reg;
    logic                         key_pend_next;

    logic [eitu_pkg::TOD_W-1:0]   prev_tod;
    logic [eitu_pkg::CPUT_W-1:0]  cpu_after_tick;
    logic [eitu_pkg::ITV_W-1:0]   itv_after_tick;
    logic                         itv_cross;
    logic                         cmp_now;
    logic [eitu_pkg::PAGE_W-1:0]  serv_page;
    logic [eitu_pkg::PAGE_W-1:0]  serv_page_new;
    logic [eitu_pkg::PARAM_W-1:0] serv_prefixed;
    eitu_pkg::result_t            res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_cmp_reg   <= '1;
            prefix_page_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (eitu_pkg::cfg_idx_t'(cfg_index))
                eitu_pkg::CFG_CLOCK_CMP:   clock_cmp_reg   <= cfg_data;
                eitu_pkg::CFG_PREFIX_BASE:
                    prefix_page_reg <= cfg_data[eitu_pkg::PAGE_HI:eitu_pkg::PAGE_LO];
                default: ;
            endcase
        end
    end

    // elapsed time counts from the previous value with the sub-unit bits cleared
    assign prev_tod       = {tod_reg[eitu_pkg::TOD_W-1:eitu_pkg::PAGE_LO],
                             eitu_pkg::PAGE_LO'(0)};
    assign cpu_after_tick = (prev_tod == '0) ? cpu_timer_reg
                          : cpu_timer_reg - item.tod_value + prev_tod;
    assign itv_after_tick = itv_reg - eitu_pkg::INTERVAL_DECREMENT;
    assign itv_cross      = itv_after_tick[eitu_pkg::ITV_W-1] && !itv_reg[eitu_pkg::ITV_W-1]
                            && (itv_reg != '0);
    assign cmp_now        = tod_reg > clock_cmp_reg;

    // swap page zero and the prefix page
    assign serv_page     = serv_param_reg[eitu_pkg::PAGE_HI:eitu_pkg::PAGE_LO];
    assign serv_page_new = (serv_page == '0) ? prefix_page_reg
                         : ((serv_page == prefix_page_reg) ? '0 : serv_page);
    assign serv_prefixed = {serv_param_reg[eitu_pkg::PARAM_W-1], serv_page_new,
                            serv_param_reg[eitu_pkg::PAGE_LO-1:0]};

    always_comb
    begin
        tod_next        = tod_reg;
        cpu_timer_next  = cpu_timer_reg;
        itv_next        = itv_reg;
        itv_pend_next   = itv_pend_reg;
        serv_pend_next  = serv_pend_reg;
        serv_param_next = serv_param_reg;
        key_pend_next   = key_pend_reg;
        res             = '0;
        unique case (item.req_type)
            eitu_pkg::REQ_TICK:
            begin
                tod_next       = item.tod_value;
                cpu_timer_next = cpu_after_tick;
                itv_next       = itv_after_tick;
                if (itv_cross)
                begin
                    itv_pend_next = 1'b1;
                end
                res.interrupt_possible = cpu_after_tick[eitu_pkg::CPUT_W-1]
                                         || (item.tod_value > clock_cmp_reg) || itv_cross;
            end
            eitu_pkg::REQ_CHECK:
            begin
                if (item.ext_mask)
                begin
                    if (cpu_timer_reg[eitu_pkg::CPUT_W-1]
                        && item.subclass_mask[eitu_pkg::SUB_CPUT])
                    begin
                        res.interrupt_source = eitu_pkg::SRC_CPUT;
                    end
                    else if (cmp_now && !item.single_step
                             && item.subclass_mask[eitu_pkg::SUB_CMP])
                    begin
                        res.interrupt_source = eitu_pkg::SRC_CMP;
                    end
                    else if (itv_pend_reg && item.subclass_mask[eitu_pkg::SUB_ITV])
                    begin
                        res.interrupt_source = eitu_pkg::SRC_ITV;
                        itv_pend_next        = 1'b0;
                    end
                    else if (serv_pend_reg && item.subclass_mask[eitu_pkg::SUB_SERV])
                    begin
                        res.interrupt_source  = eitu_pkg::SRC_SERVICE;
                        res.service_param_out = serv_prefixed;
                        serv_param_next       = serv_prefixed;
                        serv_pend_next        = 1'b0;
                    end
                    else if (key_pend_reg && item.subclass_mask[eitu_pkg::SUB_KEY])
                    begin
                        res.interrupt_source = eitu_pkg::SRC_KEY;
                        key_pend_next        = 1'b0;
                    end
                    res.interrupt_taken = (res.interrupt_source != eitu_pkg::SRC_NONE);
                end
            end
            eitu_pkg::REQ_SERVICE:
            begin
                serv_pend_next  = 1'b1;
                serv_param_next = item.service_param_in;
            end
            eitu_pkg::REQ_KEY:
            begin
                key_pend_next = 1'b1;
            end
            eitu_pkg::REQ_LOAD_CPU:
            begin
                cpu_timer_next = $unsigned(item.load_value);
            end
            eitu_pkg::REQ_LOAD_ITV:
            begin
                itv_next = $unsigned(item.load_value[eitu_pkg::ITV_W-1:0]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tod_reg        <= '0;
            cpu_timer_reg  <= '0;
            itv_reg        <= '0;
            itv_pend_reg   <= 1'b0;
            serv_pend_reg  <= 1'b0;
            serv_param_reg <= '0;
            key_pend_reg   <= 1'b0;
        end
        else if (fire)
        begin
            tod_reg        <= tod_next;
            cpu_timer_reg  <= cpu_timer_next;
            itv_reg        <= itv_next;
            itv_pend_reg   <= itv_pend_next;
            serv_pend_reg  <= serv_pend_next;
            serv_param_reg <= serv_param_next;
            key_pend_reg   <= key_pend_next;
        end
    end

    assign result = res;

    a_possible_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.interrupt_possible) |-> (item.req_type == eitu_pkg::REQ_TICK))
        else $error("interrupt_possible set on a non-tick item");

    a_taken_matches_source: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (res.interrupt_taken == (res.interrupt_source != eitu_pkg::SRC_NONE)))
        else $error("taken flag disagrees with source");

    a_param_only_service: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (res.service_param_out != '0))
        |-> (res.interrupt_source == eitu_pkg::SRC_SERVICE))
        else $error("service parameter given for another source");

    a_key_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (res.interrupt_source == eitu_pkg::SRC_KEY)) |=> !key_pend_reg)
        else $error("key latch not cleared after being taken");

endmodule

>>> rtl/eitu_out_reg.sv
`timescale 1ns / 1ps
// result register: holds one result until the master stream takes it
module eitu_out_reg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  eitu_pkg::result_t                    result,
    output eitu_pkg::stage_ctl_t                 ctl,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [eitu_pkg::OUT_DATA_W-1:0]      m_tdata
);

    logic              valid_reg;
    logic              valid_next;
    eitu_pkg::result_t result_reg;
    logic              advance;

    assign advance    = !valid_reg || m_tready;
    assign valid_next = advance ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            result_reg <= result;
        end
    end

    assign ctl.valid   = valid_reg;
    assign ctl.advance = advance;
    assign m_tvalid    = valid_reg;
    assign m_tdata     = {3'b000,
                          result_reg.interrupt_possible,
                          result_reg.service_param_out,
                          result_reg.interrupt_source,
                          result_reg.interrupt_taken};

endmodule

>>> rtl/external_interrupt_timer_unit_core.sv
`timescale 1ns / 1ps
// External interrupt and timer unit for one CPU. The block takes one item every clock
// cycle unless the master stream holds back results, and gives exactly one result per
// item, which passes the input register and then the result register. The rate rests on
// the update of the timer and latch state in the execute stage, made once per item, which
// reads the state left by the item before it. Configuration writes go to the comparator
// and prefix registers and must only happen while no item is in flight.
module external_interrupt_timer_unit_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [eitu_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tod_value, load_value, service_param_in, ext_mask, subclass_mask, single_step, pad
    input  logic [eitu_pkg::IN_DATA_W-1:0]       s_tdata,
    // req_type
    input  logic [2:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // interrupt_taken, interrupt_source, service_param_out, interrupt_possible, pad
    output logic [eitu_pkg::OUT_DATA_W-1:0]      m_tdata
);

    eitu_pkg::item_t      item;
    logic                 item_valid;
    eitu_pkg::result_t    result;
    eitu_pkg::stage_ctl_t out_ctl;
    logic                 fire;

    assign fire = item_valid && out_ctl.advance;

    eitu_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (out_ctl.advance),
        .item       (item),
        .item_valid (item_valid)
    );

    eitu_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .fire      (fire),
        .result    (result)
    );

    eitu_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_valid),
        .result   (result),
        .ctl      (out_ctl),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> sim/eitu_result_checker.sv
`timescale 1ns / 1ps
// result checker of the external interrupt and timer unit: predicts each result and compares it
module eitu_result_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [eitu_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [eitu_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic [2:0]                       s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [eitu_pkg::OUT_DATA_W-1:0]  m_tdata,
    output int unsigned                      outstanding,
    output int unsigned                      fail_count
);

    localparam logic [eitu_pkg::PARAM_W-1:0] PAGE_MASK     = 32'h7FFF_F000;
    localparam logic [eitu_pkg::TOD_W-1:0]   TOD_UNIT_MASK = 64'hFFFF_FFFF_FFFF_F000;

    typedef struct packed {
        logic                         taken;
        eitu_pkg::src_t               source;
        logic [eitu_pkg::PARAM_W-1:0] param;
        logic                         possible;
    } outcome_t;

    logic [eitu_pkg::TOD_W-1:0]   cmp_reg;
    logic [30:0]                  prefix_reg;
    logic [eitu_pkg::TOD_W-1:0]   tod_reg;
    logic [eitu_pkg::CPUT_W-1:0]  cpu_timer_reg;
    logic [eitu_pkg::ITV_W-1:0]   interval_reg;
    logic                         interval_pend;
    logic                         service_pend;
    logic [eitu_pkg::PARAM_W-1:0] service_param;
    logic                         key_pend;

    outcome_t    due_results[$];
    outcome_t    want;
    outcome_t    got;
    int unsigned mismatches;

    // page 0 and the prefix page swap places, everything else stays
    function automatic logic [eitu_pkg::PARAM_W-1:0] apply_prefix(
        input logic [eitu_pkg::PARAM_W-1:0] addr
    );
        logic [eitu_pkg::PARAM_W-1:0] page;
        logic [eitu_pkg::PARAM_W-1:0] pfx_page;
        logic [eitu_pkg::PARAM_W-1:0] new_page;
        page     = addr & PAGE_MASK;
        pfx_page = {1'b0, prefix_reg} & PAGE_MASK;
        new_page = page;
        if (page == '0)
            new_page = pfx_page;
        else if (page == pfx_page)
            new_page = '0;
        return (addr & ~PAGE_MASK) | new_page;
    endfunction

    function automatic outcome_t step_timer_unit(
        input logic [2:0]                   req,
        input logic [eitu_pkg::TOD_W-1:0]   tod_in,
        input logic [eitu_pkg::CPUT_W-1:0]  load_in,
        input logic [eitu_pkg::PARAM_W-1:0] sp_in,
        input logic                         mask,
        input logic [eitu_pkg::SUB_W-1:0]   sub,
        input logic                         step
    );
        outcome_t                    o;
        logic [eitu_pkg::TOD_W-1:0]  prev;
        logic [eitu_pkg::TOD_W-1:0]  elapsed;
        logic [eitu_pkg::ITV_W-1:0]  old_itv;
        logic [eitu_pkg::ITV_W-1:0]  new_itv;
        o = '0;
        case (req)
            eitu_pkg::REQ_TICK:
            begin
                prev          = tod_reg & TOD_UNIT_MASK;
                elapsed       = (prev == '0) ? '0 : tod_in - prev;
                old_itv       = interval_reg;
                new_itv       = old_itv - eitu_pkg::INTERVAL_DECREMENT;
                tod_reg       = tod_in;
                cpu_timer_reg = cpu_timer_reg - elapsed;
                if (cpu_timer_reg[eitu_pkg::CPUT_W-1] || tod_reg > cmp_reg)
                    o.possible = 1'b1;
                interval_reg = new_itv;
                // crossing from strictly positive to negative
                if (new_itv[eitu_pkg::ITV_W-1] && !old_itv[eitu_pkg::ITV_W-1] && old_itv != '0)
                begin
                    interval_pend = 1'b1;
                    o.possible    = 1'b1;
                end
            end
            eitu_pkg::REQ_CHECK:
            begin
                if (mask)
                begin
                    if (cpu_timer_reg[eitu_pkg::CPUT_W-1] && sub[eitu_pkg::SUB_CPUT])
                        o.source = eitu_pkg::SRC_CPUT;
                    else if (tod_reg > cmp_reg && !step && sub[eitu_pkg::SUB_CMP])
                        o.source = eitu_pkg::SRC_CMP;
                    else if (interval_pend && sub[eitu_pkg::SUB_ITV])
                    begin
                        o.source      = eitu_pkg::SRC_ITV;
                        interval_pend = 1'b0;
                    end
                    else if (service_pend && sub[eitu_pkg::SUB_SERV])
                    begin
                        o.source      = eitu_pkg::SRC_SERVICE;
                        service_param = apply_prefix(service_param);
                        o.param       = service_param;
                        service_pend  = 1'b0;
                    end
                    else if (key_pend && sub[eitu_pkg::SUB_KEY])
                    begin
                        o.source = eitu_pkg::SRC_KEY;
                        key_pend = 1'b0;
                    end
                    o.taken = (o.source != eitu_pkg::SRC_NONE);
                end
            end
            eitu_pkg::REQ_SERVICE:
            begin
                service_pend  = 1'b1;
                service_param = sp_in;
            end
            eitu_pkg::REQ_KEY:      key_pend = 1'b1;
            eitu_pkg::REQ_LOAD_CPU: cpu_timer_reg = load_in;
            eitu_pkg::REQ_LOAD_ITV: interval_reg = load_in[eitu_pkg::ITV_W-1:0];
            default: ;
        endcase
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_reg       = '1;
            prefix_reg    = '0;
            tod_reg       = '0;
            cpu_timer_reg = '0;
            interval_reg  = '0;
            interval_pend = 1'b0;
            service_pend  = 1'b0;
            service_param = '0;
            key_pend      = 1'b0;
            due_results.delete();
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            mismatches = 0;
            if (cfg_we)
            begin
                case (eitu_pkg::cfg_idx_t'(cfg_index))
                    eitu_pkg::CFG_CLOCK_CMP:   cmp_reg = cfg_data;
                    eitu_pkg::CFG_PREFIX_BASE: prefix_reg = cfg_data[30:0];
                    default: ;
                endcase
            end
            // results leave before this edge's item enters, so pop first
            if (m_tvalid && m_tready)
            begin
                got.taken    = m_tdata[0];
                got.source   = eitu_pkg::src_t'(m_tdata[3:1]);
                got.param    = m_tdata[35:4];
                got.possible = m_tdata[36];
                if (due_results.size() == 0)
                begin
                    $error("result transfer with nothing expected: %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.taken !== want.taken)
                    begin
                        $error("interrupt_taken expected %0d actual %0d", want.taken, got.taken);
                        mismatches++;
                    end
                    if (got.source !== want.source)
                    begin
                        $error("interrupt_source expected %0d actual %0d",
                               want.source, got.source);
                        mismatches++;
                    end
                    if (got.param !== want.param)
                    begin
                        $error("service_param_out expected %h actual %h", want.param, got.param);
                        mismatches++;
                    end
                    if (got.possible !== want.possible)
                    begin
                        $error("interrupt_possible expected %0d actual %0d",
                               want.possible, got.possible);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                due_results.push_back(step_timer_unit(s_tuser, s_tdata[63:0], s_tdata[127:64],
                                                      s_tdata[159:128], s_tdata[160],
                                                      s_tdata[165:161], s_tdata[166]));
            outstanding <= due_results.size();
            fail_count  <= fail_count + mismatches;
        end
    end

endmodule

>>> sim/external_interrupt_timer_unit_core_tb.sv
`timescale 1ns / 1ps
// testbench top of the external interrupt and timer unit: stimulus, watchdog and verdict
module external_interrupt_timer_unit_core_tb;

    localparam int unsigned IDLE_LIMIT     = 4000;
    localparam int unsigned PHASES         = 6;
    localparam int unsigned ITEMS_PER_PASS = 258;
    localparam logic [eitu_pkg::PARAM_W-1:0] PAGE_MASK = 32'h7FFF_F000;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic                            cfg_index = 1'b0;
    logic [eitu_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            s_tvalid  = 1'b0;
    logic [eitu_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
    logic [2:0]                      s_tuser   = '0;
    logic                            m_tready  = 1'b0;
    wire                             s_tready;
    wire                             m_tvalid;
    wire [eitu_pkg::OUT_DATA_W-1:0]  m_tdata;

    int unsigned outstanding;
    int unsigned fail_count;
    int unsigned burst_left = 0;
    int unsigned idle_cycles = 0;
    logic [eitu_pkg::TOD_W-1:0] tod_now    = '0;
    logic [30:0]                prefix_now = '0;
    logic [10:0]                rx_cycle   = '0;

    external_interrupt_timer_unit_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    eitu_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .outstanding(outstanding),
        .fail_count (fail_count)
    );

    always #10 clk = ~clk;

    // receiver walks through four stall patterns
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1'b1;
        case (rx_cycle[10:9])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 99) < 70);
            2'd2: m_tready <= (rx_cycle[2:0] != 3'd5) && (rx_cycle[2:0] != 3'd6);
            default: m_tready <= (rx_cycle[4:0] == 5'd0) || ($urandom_range(0, 3) == 0);
        endcase
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("external_interrupt_timer_unit_core_tb NOT OK");
        $finish;
    end

    task automatic push_item(
        input logic [2:0]                   req,
        input logic [eitu_pkg::TOD_W-1:0]   tod,
        input logic [eitu_pkg::CPUT_W-1:0]  load,
        input logic [eitu_pkg::PARAM_W-1:0] sp,
        input logic                         mask,
        input logic [eitu_pkg::SUB_W-1:0]   sub,
        input logic                         step
    );
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
        end
        s_tdata  <= {1'b0, step, sub, mask, sp, load, tod};
        s_tuser  <= req;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        burst_left--;
    endtask

    // hold off the sender until every result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(
        input logic [eitu_pkg::TOD_W-1:0]      cmp,
        input logic [eitu_pkg::CFG_DATA_W-1:0] pfx
    );
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= eitu_pkg::CFG_CLOCK_CMP;
        cfg_data  <= cmp;
        @(posedge clk);
        cfg_index <= eitu_pkg::CFG_PREFIX_BASE;
        cfg_data  <= pfx;
        @(posedge clk);
        cfg_we     <= 1'b0;
        prefix_now  = pfx[30:0];
    endtask

    task automatic random_item();
        logic [2:0]                   req;
        logic [eitu_pkg::TOD_W-1:0]   tod;
        logic [eitu_pkg::CPUT_W-1:0]  load;
        logic [eitu_pkg::PARAM_W-1:0] sp;
        int unsigned                  pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            req = eitu_pkg::REQ_TICK;
        else if (pick < 63)
            req = eitu_pkg::REQ_CHECK;
        else if (pick < 71)
            req = eitu_pkg::REQ_SERVICE;
        else if (pick < 78)
            req = eitu_pkg::REQ_KEY;
        else if (pick < 87)
            req = eitu_pkg::REQ_LOAD_CPU;
        else if (pick < 96)
            req = eitu_pkg::REQ_LOAD_ITV;
        else
            req = 3'($urandom_range(6, 7));
        tod  = {$urandom, $urandom};
        load = {$urandom, $urandom};
        sp   = $urandom;
        if (req == eitu_pkg::REQ_TICK)
        begin
            // mostly a clock that moves forward by up to three units
            case ($urandom_range(0, 19))
                0: ;
                1: tod = '0;
                2: tod = '1;
                default: tod = tod_now + 64'($urandom_range(0, 'h3000));
            endcase
            tod_now = tod;
        end
        else if (req == eitu_pkg::REQ_LOAD_CPU)
        begin
            case ($urandom_range(0, 3))
                0, 1: load = 64'($urandom_range(0, 'h40000));
                2: load = {1'b0, load[62:0]};
                default: ;
            endcase
        end
        else if (req == eitu_pkg::REQ_LOAD_ITV)
        begin
            case ($urandom_range(0, 3))
                0, 1: load[31:0] = 32'($urandom_range(0, 3000));
                2: load[31:0] = 32'h7FFF_FFFF - 32'($urandom_range(0, 1000));
                default: ;
            endcase
        end
        else if (req == eitu_pkg::REQ_SERVICE)
        begin
            case ($urandom_range(0, 3))
                0: sp = sp & ~PAGE_MASK;
                1: sp = (sp & ~PAGE_MASK) | ({1'b0, prefix_now} & PAGE_MASK);
                default: ;
            endcase
        end
        push_item(req, tod, load, sp, $urandom_range(0, 9) != 0,
                  ($urandom_range(0, 3) == 0) ? 5'h1F : 5'($urandom),
                  $urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: comparator all ones, prefix zero
        push_item(eitu_pkg::REQ_CHECK, '0, '0, '0, 1'b1, 5'h1F, 1'b0);
        // interval timer at zero does not count as a crossing
        push_item(eitu_pkg::REQ_TICK, '0, '0, '0, 1'b0, 5'h00, 1'b0);
        push_item(eitu_pkg::REQ_LOAD_ITV, '0, 64'hFFFF_FFFF_0000_0064, '0, 1'b0, 5'h00, 1'b0);
        push_item(eitu_pkg::REQ_TICK, 64'h5000, '0, '0, 1'b0, 5'h00, 1'b0);
        push_item(eitu_pkg::REQ_LOAD_CPU, '0, 64'd5, '0, 1'b0, 5'h00, 1'b0);
        push_item(eitu_pkg::REQ_TICK, 64'h5FFF, '0, '0, 1'b0, 5'h00, 1'b0);
        push_item(eitu_pkg::REQ_SERVICE, '0, '0, 32'h0000_0123, 1'b0, 5'h00, 1'b0);
        push_item(eitu_pkg::REQ_KEY, '0, '0, '0, 1'b0, 5'h00, 1'b0);
        push_item(eitu_pkg::REQ_CHECK, '0, '0, '0, 1'b0, 5'h1F, 1'b0);
        push_item(eitu_pkg::REQ_CHECK, '0, '0, '0, 1'b1, 5'h01, 1'b0);
        push_item(eitu_pkg::REQ_CHECK, '0, '0, '0, 1'b1, 5'h02, 1'b0);
        push_item(eitu_pkg::REQ_CHECK, '0, '0, '0, 1'b1, 5'h1E, 1'b0);
        push_item(eitu_pkg::REQ_CHECK, '0, '0, '0, 1'b1, 5'h18, 1'b0);
        push_item(eitu_pkg::REQ_CHECK, '0, '0, '0, 1'b1, 5'h10, 1'b0);
        push_item(3'd6, '1, '1, '1, 1'b1, 5'h1F, 1'b1);
        push_item(3'd7, '1, '1, '1, 1'b1, 5'h1F, 1'b1);

        // comparator always passed, unaligned prefix at the top page
        load_settings('0, 64'hFFFF_FFFF_7FFF_FFFF);
        push_item(eitu_pkg::REQ_CHECK, '0, '0, '0, 1'b1, 5'h02, 1'b1);
        push_item(eitu_pkg::REQ_CHECK, '0, '0, '0, 1'b1, 5'h02, 1'b0);
        push_item(eitu_pkg::REQ_SERVICE, '0, '0, 32'h8000_0ABC, 1'b0, 5'h00, 1'b0);
        // a second raise replaces the parameter; the prefix page maps to page 0
        push_item(eitu_pkg::REQ_SERVICE, '0, '0, 32'h7FFF_F123, 1'b0, 5'h00, 1'b0);
        push_item(eitu_pkg::REQ_CHECK, '0, '0, '0, 1'b1, 5'h08, 1'b0);
        push_item(eitu_pkg::REQ_SERVICE, '0, '0, 32'h8000_0ABC, 1'b0, 5'h00, 1'b0);
        push_item(eitu_pkg::REQ_CHECK, '0, '0, '0, 1'b1, 5'h08, 1'b0);
        push_item(eitu_pkg::REQ_LOAD_CPU, '0, 64'h7FFF_FFFF_FFFF_FFFF, '0, 1'b0, 5'h00, 1'b0);
        push_item(eitu_pkg::REQ_LOAD_ITV, '0, 64'h0000_0000_7FFF_FFFF, '0, 1'b0, 5'h00, 1'b0);
        push_item(eitu_pkg::REQ_TICK, '1, '0, '0, 1'b0, 5'h00, 1'b0);
        push_item(eitu_pkg::REQ_LOAD_CPU, '0, 64'h8000_0000_0000_0000, '0, 1'b0, 5'h00, 1'b0);
        tod_now = '1;

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: load_settings('0, 64'h7FFF_FFFF);
                1: load_settings('1, '0);
                2: load_settings(tod_now + 64'($urandom_range(0, 'h40000)), 64'($urandom));
                3: load_settings({$urandom, $urandom}, {$urandom, $urandom});
                4: load_settings(tod_now + 64'($urandom_range(0, 'h8000)), 64'h1000);
                default: load_settings(64'hFFFF_FFFF_FFFF_FFFE, 64'($urandom));
            endcase
            for (int n = 0; n < ITEMS_PER_PASS; n++)
            begin
                if ($urandom_range(0, 199) == 0)
                    drain_results();
                random_item();
            end
        end

        drain_results();
        repeat (6) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("external_interrupt_timer_unit_core_tb OK");
        else
            $display("external_interrupt_timer_unit_core_tb NOT OK");
        $finish;
    end

endmodule
